// ----- hw/rtl/shabc_pkg.sv -----
// Shared types, constants and the round-constant table for the SHA-256 block compressor.
// Used by shabc_ctrl, shabc_dp and sha256_block_compress_core; depends on nothing.
package shabc_pkg;

	localparam int WORD_W     = 32;
	localparam int NUM_CV     = 8;
	localparam int WIN_DEPTH  = 16;
	localparam int NUM_ROUNDS = 64;
	localparam int ROUND_W    = $clog2(NUM_ROUNDS);
	localparam int WCNT_W     = $clog2(WIN_DEPTH);
	localparam int OIDX_W     = $clog2(NUM_CV);
	localparam int CFG_IDX_W  = 4;
	localparam int OUT_DATA_W = 40;

	localparam logic [WCNT_W-1:0]  LAST_WORD_CNT = WCNT_W'(WIN_DEPTH - 1);
	localparam logic [ROUND_W-1:0] LAST_ROUND    = ROUND_W'(NUM_ROUNDS - 1);
	localparam logic [OIDX_W-1:0]  LAST_OUT_IDX  = OIDX_W'(NUM_CV - 1);

	// Standard SHA-256 initial hash values, reset contents of the init registers
	localparam logic [WORD_W-1:0] IV_RESET [NUM_CV] = '{
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
	};

	typedef enum logic [1:0] {
		ST_LOAD,
		ST_ROUND,
		ST_FINAL
	} state_t;

	// Commands from the controller to the datapath
	typedef struct packed {
		logic               load_word;
		logic               start_msg;
		logic               init_vars;
		logic               do_round;
		logic [ROUND_W-1:0] round_idx;
		logic               finish;
		logic               out_shift;
	} dp_cmd_t;

	// Round constants
	function automatic logic [WORD_W-1:0] round_k(input logic [ROUND_W-1:0] r);
		logic [WORD_W-1:0] k;
		case (r)
			6'd0:  k = 32'h428a2f98;  6'd1:  k = 32'h71374491;
			6'd2:  k = 32'hb5c0fbcf;  6'd3:  k = 32'he9b5dba5;
			6'd4:  k = 32'h3956c25b;  6'd5:  k = 32'h59f111f1;
			6'd6:  k = 32'h923f82a4;  6'd7:  k = 32'hab1c5ed5;
			6'd8:  k = 32'hd807aa98;  6'd9:  k = 32'h12835b01;
			6'd10: k = 32'h243185be;  6'd11: k = 32'h550c7dc3;
			6'd12: k = 32'h72be5d74;  6'd13: k = 32'h80deb1fe;
			6'd14: k = 32'h9bdc06a7;  6'd15: k = 32'hc19bf174;
			6'd16: k = 32'he49b69c1;  6'd17: k = 32'hefbe4786;
			6'd18: k = 32'h0fc19dc6;  6'd19: k = 32'h240ca1cc;
			6'd20: k = 32'h2de92c6f;  6'd21: k = 32'h4a7484aa;
			6'd22: k = 32'h5cb0a9dc;  6'd23: k = 32'h76f988da;
			6'd24: k = 32'h983e5152;  6'd25: k = 32'ha831c66d;
			6'd26: k = 32'hb00327c8;  6'd27: k = 32'hbf597fc7;
			6'd28: k = 32'hc6e00bf3;  6'd29: k = 32'hd5a79147;
			6'd30: k = 32'h06ca6351;  6'd31: k = 32'h14292967;
			6'd32: k = 32'h27b70a85;  6'd33: k = 32'h2e1b2138;
			6'd34: k = 32'h4d2c6dfc;  6'd35: k = 32'h53380d13;
			6'd36: k = 32'h650a7354;  6'd37: k = 32'h766a0abb;
			6'd38: k = 32'h81c2c92e;  6'd39: k = 32'h92722c85;
			6'd40: k = 32'ha2bfe8a1;  6'd41: k = 32'ha81a664b;
			6'd42: k = 32'hc24b8b70;  6'd43: k = 32'hc76c51a3;
			6'd44: k = 32'hd192e819;  6'd45: k = 32'hd6990624;
			6'd46: k = 32'hf40e3585;  6'd47: k = 32'h106aa070;
			6'd48: k = 32'h19a4c116;  6'd49: k = 32'h1e376c08;
			6'd50: k = 32'h2748774c;  6'd51: k = 32'h34b0bcb5;
			6'd52: k = 32'h391c0cb3;  6'd53: k = 32'h4ed8aa4a;
			6'd54: k = 32'h5b9cca4f;  6'd55: k = 32'h682e6ff3;
			6'd56: k = 32'h748f82ee;  6'd57: k = 32'h78a5636f;
			6'd58: k = 32'h84c87814;  6'd59: k = 32'h8cc70208;
			6'd60: k = 32'h90befffa;  6'd61: k = 32'ha4506ceb;
			6'd62: k = 32'hbef9a3f7;  default: k = 32'hc67178f2;
		endcase
		return k;
	endfunction

endpackage

// ----- hw/rtl/shabc_ctrl.sv -----
// Sequencer for the SHA-256 block compressor: word count, round count, output handshake.
// Depends on shabc_pkg; drives shabc_dp through a dp_cmd_t command bundle.
module shabc_ctrl
	import shabc_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic              in_start,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [OIDX_W-1:0] out_idx,
	output logic              out_last,
	output dp_cmd_t           cmd
);

	state_t             state_q, state_nx;
	logic [WCNT_W-1:0]  wcnt_q;
	logic [ROUND_W-1:0] round_q;
	logic               ovalid_q;
	logic [OIDX_W-1:0]  oidx_q;
	logic               in_acc, out_acc, block_done;

	assign in_acc     = in_valid && in_ready;
	assign out_acc    = ovalid_q && out_ready;
	// a start word becomes word 0, so it can never complete a block
	assign block_done = in_acc && !in_start && (wcnt_q == LAST_WORD_CNT);

	// next state
	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			ST_LOAD: begin
				if (block_done) state_nx = ST_ROUND;
			end
			ST_ROUND: begin
				if (round_q == LAST_ROUND) state_nx = ST_FINAL;
			end
			ST_FINAL: begin
				if (!ovalid_q) state_nx = ST_LOAD;
			end
			default: state_nx = ST_LOAD;
		endcase
	end

	// outputs
	always_comb begin
		in_ready      = 1'b0;
		cmd           = '0;
		cmd.round_idx = round_q;
		cmd.out_shift = out_acc;
		unique case (state_q)
			ST_LOAD: begin
				in_ready      = 1'b1;
				cmd.load_word = in_acc;
				cmd.start_msg = in_acc && in_start;
				cmd.init_vars = block_done;
			end
			ST_ROUND: begin
				cmd.do_round = 1'b1;
			end
			ST_FINAL: begin
				cmd.finish = !ovalid_q;
			end
			default: begin
				in_ready = 1'b0;
			end
		endcase
	end

	assign out_valid = ovalid_q;
	assign out_idx   = oidx_q;
	assign out_last  = (oidx_q == LAST_OUT_IDX);

	// counters and state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_LOAD;
			wcnt_q   <= '0;
			round_q  <= '0;
			ovalid_q <= 1'b0;
			oidx_q   <= '0;
		end else begin
			state_q <= state_nx;
			if (in_acc) begin
				wcnt_q <= in_start ? WCNT_W'(1) : wcnt_q + WCNT_W'(1);
			end
			if (state_q == ST_ROUND) round_q <= round_q + ROUND_W'(1);
			else                     round_q <= '0;
			// digest word delivery
			if (cmd.finish) begin
				ovalid_q <= 1'b1;
				oidx_q   <= '0;
			end else if (out_acc) begin
				oidx_q <= oidx_q + OIDX_W'(1);
				if (oidx_q == LAST_OUT_IDX) ovalid_q <= 1'b0;
			end
		end
	end

	// the sixteenth word of a block starts round 0 next cycle
	a_block_to_rounds: assert property (@(posedge clk) disable iff (!arst_n)
		block_done |=> (state_q == ST_ROUND) && (round_q == '0))
		else $error("block completion did not start the rounds");

	// after the last round the add-back follows
	a_rounds_end: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_ROUND) && (round_q == LAST_ROUND) |=> state_q == ST_FINAL)
		else $error("round sequence did not end in the final add");

	// the output buffer is only overwritten when drained
	a_finish_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish |-> !ovalid_q)
		else $error("digest buffer overwritten while busy");

	// each digest run begins at word 0
	a_idx_start: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(ovalid_q) |-> oidx_q == '0)
		else $error("digest run did not start at index 0");

endmodule

// ----- hw/rtl/shabc_dp.sv -----
// Datapath of the SHA-256 block compressor: init registers, chaining value,
// schedule window, round logic and digest output buffer. Depends on shabc_pkg.
module shabc_dp
	import shabc_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  dp_cmd_t              cmd,
	input  logic [WORD_W-1:0]    in_word,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_idx,
	input  logic [WORD_W-1:0]    cfg_wdata,
	output logic [WORD_W-1:0]    out_word
);

	logic [WORD_W-1:0] init_q [NUM_CV];
	logic [WORD_W-1:0] cv_q   [NUM_CV];
	logic [WORD_W-1:0] var_q  [NUM_CV];
	logic [WORD_W-1:0] obuf_q [NUM_CV];
	logic [WORD_W-1:0] win_q  [WIN_DEPTH];

	logic [WORD_W-1:0] w_new, t1, t2, ch, maj, s0, s1;
	logic [WORD_W-1:0] cv_sum [NUM_CV];

	function automatic logic [WORD_W-1:0] ror(input logic [WORD_W-1:0] x, input int n);
		return (x >> n) | (x << (WORD_W - n));
	endfunction

	// schedule expansion: word t+16 from the current window
	assign w_new = (ror(win_q[14], 17) ^ ror(win_q[14], 19) ^ (win_q[14] >> 10))
		+ win_q[9]
		+ (ror(win_q[1], 7) ^ ror(win_q[1], 18) ^ (win_q[1] >> 3))
		+ win_q[0];

	// one compression round
	assign ch  = (var_q[4] & var_q[5]) ^ (~var_q[4] & var_q[6]);
	assign s1  = ror(var_q[4], 6) ^ ror(var_q[4], 11) ^ ror(var_q[4], 25);
	assign t1  = win_q[0] + round_k(cmd.round_idx) + var_q[7] + ch + s1;
	assign s0  = ror(var_q[0], 2) ^ ror(var_q[0], 13) ^ ror(var_q[0], 22);
	assign maj = (var_q[0] & var_q[1]) ^ (var_q[0] & var_q[2]) ^ (var_q[1] & var_q[2]);
	assign t2  = maj + s0;

	// add-back into the chaining value
	always_comb begin
		for (int i = 0; i < NUM_CV; i++) cv_sum[i] = cv_q[i] + var_q[i];
	end

	assign out_word = obuf_q[0];

	// init registers and chaining value
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			init_q <= IV_RESET;
			cv_q   <= IV_RESET;
		end else begin
			if (cfg_we && (cfg_idx < CFG_IDX_W'(NUM_CV))) begin
				init_q[cfg_idx[OIDX_W-1:0]] <= cfg_wdata;
			end
			if (cmd.start_msg)   cv_q <= init_q;
			else if (cmd.finish) cv_q <= cv_sum;
		end
	end

	// schedule window: shift line, fed by input words or expansion
	always_ff @(posedge clk) begin
		if (cmd.load_word || cmd.do_round) begin
			for (int i = 0; i < WIN_DEPTH - 1; i++) win_q[i] <= win_q[i+1];
			win_q[WIN_DEPTH-1] <= cmd.load_word ? in_word : w_new;
		end
	end

	// working variables
	always_ff @(posedge clk) begin
		if (cmd.init_vars) begin
			var_q <= cv_q;
		end else if (cmd.do_round) begin
			var_q[7] <= var_q[6];
			var_q[6] <= var_q[5];
			var_q[5] <= var_q[4];
			var_q[4] <= var_q[3] + t1;
			var_q[3] <= var_q[2];
			var_q[2] <= var_q[1];
			var_q[1] <= var_q[0];
			var_q[0] <= t1 + t2;
		end
	end

	// digest output buffer, shifted out one word per request
	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			obuf_q <= cv_sum;
		end else if (cmd.out_shift) begin
			for (int i = 0; i < NUM_CV - 1; i++) obuf_q[i] <= obuf_q[i+1];
			obuf_q[NUM_CV-1] <= obuf_q[NUM_CV-1];
		end
	end

endmodule

// ----- hw/rtl/sha256_block_compress_core.sv -----
// Top level of the SHA-256 block compressor: stream ports, config port, ctrl + datapath.
// Depends on shabc_pkg, shabc_ctrl and shabc_dp.
//
// Takes a padded message as 32-bit big-endian words, sixteen per block; tuser marks the
// first word of a message and reloads the chaining value from the eight init registers
// (config indexes 0..7, others ignored). Words are taken one per cycle; after the
// sixteenth word the input stalls through the 64 rounds (one round per cycle in a single
// round unit) and the add-back. The eight digest words then leave through a separate
// output buffer, lowest index first, with tlast on index 7; the next block's words are
// accepted while they drain, and the add-back of that next block waits until the buffer
// is empty.
module sha256_block_compress_core
	import shabc_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	// input words
	input  logic                  s_axis_tvalid,
	output logic                  s_axis_tready,
	input  logic [WORD_W-1:0]     s_axis_tdata,   // [31:0] message_word
	input  logic [0:0]            s_axis_tuser,   // [0] start_message
	// digest words
	output logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	output logic [OUT_DATA_W-1:0] m_axis_tdata,   // [31:0] digest_word, [34:32] word_index
	output logic                  m_axis_tlast,
	// config writes
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [WORD_W-1:0]     cfg_data
);

	dp_cmd_t           cmd;
	logic [OIDX_W-1:0] out_idx;
	logic [WORD_W-1:0] out_word;

	assign cfg_ready = 1'b1;

	shabc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.in_start  (s_axis_tuser[0]),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_idx   (out_idx),
		.out_last  (m_axis_tlast),
		.cmd       (cmd)
	);

	shabc_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.in_word   (s_axis_tdata),
		.cfg_we    (cfg_valid && cfg_ready),
		.cfg_idx   (cfg_index),
		.cfg_wdata (cfg_data),
		.out_word  (out_word)
	);

	// pack digest word and its index, zero-filled to whole bytes
	assign m_axis_tdata = {(OUT_DATA_W - WORD_W - OIDX_W)'(0), out_idx, out_word};

endmodule

// ----- tb/tb_sha256_block_compress_core.sv -----
// Self-checking testbench for sha256_block_compress_core: directed table, then random messages.
// Depends on shabc_pkg and the core; holds its own SHA-256 compression model for prediction.
`timescale 1ns / 100ps

module tb_sha256_block_compress_core;
	import shabc_pkg::*;

	typedef logic [WORD_W-1:0] word_t;

	// Config register indexes; anything above the last init word is unmapped
	localparam logic [CFG_IDX_W-1:0] REG_INIT_WORD0 = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_INIT_WORD7 = CFG_IDX_W'(7);
	localparam logic [CFG_IDX_W-1:0] REG_LAST_INDEX = '1;

	localparam int DIGEST_LSB  = 0;
	localparam int INDEX_LSB   = WORD_W;
	localparam int HOLD_OFF    = 100;
	localparam int CYCLE_LIMIT = 300000;

	localparam word_t ROUND_CONST [NUM_ROUNDS] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
	};

	// Known digest of the one-block message "abc" from the standard initial value
	localparam word_t ABC_DIGEST [NUM_CV] = '{
		32'hba7816bf, 32'h8f01cfea, 32'h414140de, 32'h5dae2223,
		32'hb00361a3, 32'h96177a9c, 32'hb410ff61, 32'hf20015ad
	};

	typedef struct packed {
		word_t             word;
		logic              start;
		logic              typed;   // block ends here with the typed-in digest
	} dir_row_t;

	typedef struct packed {
		word_t             digest;
		logic [OIDX_W-1:0] idx;
		logic              last;
	} digest_out_t;

	typedef struct packed {
		logic [CFG_IDX_W-1:0] idx;
		word_t                data;
	} cfg_req_t;

	// "abc" without a start right after reset, then a start in mid-block
	localparam int NUM_DIRECTED = 25;
	localparam dir_row_t DIRECTED [NUM_DIRECTED] = '{
		'{32'h61626380, 1'b0, 1'b0}, '{32'h00000000, 1'b0, 1'b0},
		'{32'h00000000, 1'b0, 1'b0}, '{32'h00000000, 1'b0, 1'b0},
		'{32'h00000000, 1'b0, 1'b0}, '{32'h00000000, 1'b0, 1'b0},
		'{32'h00000000, 1'b0, 1'b0}, '{32'h00000000, 1'b0, 1'b0},
		'{32'h00000000, 1'b0, 1'b0}, '{32'h00000000, 1'b0, 1'b0},
		'{32'h00000000, 1'b0, 1'b0}, '{32'h00000000, 1'b0, 1'b0},
		'{32'h00000000, 1'b0, 1'b0}, '{32'h00000000, 1'b0, 1'b0},
		'{32'h00000000, 1'b0, 1'b0}, '{32'h00000018, 1'b0, 1'b1},
		'{32'hffffffff, 1'b1, 1'b0}, '{32'hffffffff, 1'b0, 1'b0},
		'{32'hffffffff, 1'b0, 1'b0}, '{32'hffffffff, 1'b0, 1'b0},
		'{32'hffffffff, 1'b0, 1'b0}, '{32'h00000000, 1'b1, 1'b0},
		'{32'h80000000, 1'b0, 1'b0}, '{32'h00000000, 1'b0, 1'b0},
		'{32'hffffffff, 1'b0, 1'b0}
	};

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  s_axis_tvalid = 1'b0;
	logic                  s_axis_tready;
	logic [WORD_W-1:0]     s_axis_tdata = '0;
	logic [0:0]            s_axis_tuser = '0;
	logic                  m_axis_tvalid;
	logic                  m_axis_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_axis_tdata;
	logic                  m_axis_tlast;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [WORD_W-1:0]     cfg_data = '0;

	// Model state
	word_t             init_regs [NUM_CV] = IV_RESET;
	word_t             chain     [NUM_CV] = IV_RESET;
	word_t             sched     [WIN_DEPTH];
	logic [WCNT_W-1:0] words_in_block = '0;

	digest_out_t digest_q [$];
	int          send_idle_pct = 0;
	int          rcv_stall_pct = 0;
	int          errors = 0;
	int          words_sent = 0;
	int          blocks_done = 0;
	int          digests_checked = 0;
	int          cfg_writes = 0;
	int          cycle_cnt = 0;

	sha256_block_compress_core dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	initial begin
		forever #6 clk = ~clk;
	end

	function automatic word_t rotr(input word_t x, input int n);
		return (x >> n) | (x << (WORD_W - n));
	endfunction

	// 64 rounds over the schedule window, then add back into the chaining value
	function automatic void compress_chain();
		word_t v [NUM_CV];
		word_t w, x, y, t1, t2, ch, maj, s0, s1;
		v = chain;
		for (int r = 0; r < NUM_ROUNDS; r++) begin
			if (r < WIN_DEPTH) begin
				w = sched[r];
			end else begin
				x = sched[(r - 2) % WIN_DEPTH];
				y = sched[(r - 15) % WIN_DEPTH];
				w = (rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10)) + sched[(r - 7) % WIN_DEPTH]
				  + (rotr(y, 7) ^ rotr(y, 18) ^ (y >> 3)) + sched[r % WIN_DEPTH];
				sched[r % WIN_DEPTH] = w;
			end
			ch  = (v[4] & v[5]) ^ (~v[4] & v[6]);
			s1  = rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25);
			t1  = w + ROUND_CONST[r] + v[7] + ch + s1;
			s0  = rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22);
			maj = (v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]);
			t2  = maj + s0;
			for (int i = NUM_CV - 1; i > 0; i--)
				v[i] = v[i-1];
			v[4] = v[4] + t1;
			v[0] = t1 + t2;
		end
		for (int i = 0; i < NUM_CV; i++)
			chain[i] = chain[i] + v[i];
	endfunction

	// Returns 1 when the word completes a block (chain then holds the new digest)
	function automatic bit take_word(input word_t w, input bit st);
		if (st) begin
			chain = init_regs;
			words_in_block = '0;
		end
		sched[words_in_block] = w;
		words_in_block = words_in_block + 1'b1;
		if (words_in_block != '0)
			return 1'b0;
		compress_chain();
		return 1'b1;
	endfunction

	function automatic word_t rand_word();
		case ($urandom_range(9))
			0:       return '0;
			1:       return '1;
			default: return $urandom;
		endcase
	endfunction

	// Present one word, wait for its request, update the digest expectations
	task automatic send_word(input word_t w, input bit st, input bit typed);
		digest_out_t d;
		while ($urandom_range(99) < send_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= w;
		s_axis_tuser  <= st;
		do @(posedge clk); while (!(s_axis_tvalid && s_axis_tready));
		words_sent++;
		if (take_word(w, st)) begin
			blocks_done++;
			for (int i = 0; i < NUM_CV; i++) begin
				d.digest = typed ? ABC_DIGEST[i] : chain[i];
				d.idx    = OIDX_W'(i);
				d.last   = (d.idx == LAST_OUT_IDX);
				digest_q.push_back(d);
			end
		end
	endtask

	// Hold the input off until every digest word is out, then let the block settle
	task automatic wait_drained();
		s_axis_tvalid <= 1'b0;
		do @(posedge clk); while (digest_q.size() != 0);
		repeat (HOLD_OFF) @(posedge clk);
	endtask

	// Write all eight init words in random order plus one unmapped index
	task automatic program_init(input word_t vals [NUM_CV]);
		cfg_req_t reqs [$];
		cfg_req_t q;
		for (int i = 0; i < NUM_CV; i++) begin
			q.idx  = REG_INIT_WORD0 + CFG_IDX_W'(i);
			q.data = vals[i];
			reqs.push_back(q);
		end
		q.idx  = CFG_IDX_W'($urandom_range(REG_LAST_INDEX, REG_INIT_WORD7 + 1));
		q.data = $urandom;
		reqs.push_back(q);
		reqs.shuffle();
		foreach (reqs[k]) begin
			cfg_valid <= 1'b1;
			cfg_index <= reqs[k].idx;
			cfg_data  <= reqs[k].data;
			do @(posedge clk); while (!(cfg_valid && cfg_ready));
			cfg_writes++;
			if (reqs[k].idx <= REG_INIT_WORD7)
				init_regs[reqs[k].idx - REG_INIT_WORD0] = reqs[k].data;
		end
		cfg_valid <= 1'b0;
	endtask

	// One random stretch: mostly whole messages, some chained, cut short or noisy
	task automatic send_segment();
		int kind;
		int n;
		kind = $urandom_range(99);
		if (kind < 65) begin
			n = WIN_DEPTH * $urandom_range(2, 1);
			for (int j = 0; j < n; j++)
				send_word(rand_word(), j == 0, 1'b0);
		end else if (kind < 80) begin
			for (int j = 0; j < WIN_DEPTH; j++)
				send_word(rand_word(), 1'b0, 1'b0);
		end else if (kind < 92) begin
			n = $urandom_range(WIN_DEPTH - 1, 1);
			for (int j = 0; j < n; j++)
				send_word(rand_word(), j == 0, 1'b0);
		end else begin
			n = $urandom_range(8, 1);
			for (int j = 0; j < n; j++)
				send_word(rand_word(), $urandom_range(1), 1'b0);
		end
		if ($urandom_range(9) == 0)
			wait_drained();
	endtask

	// Receiver stalls
	always @(posedge clk) begin
		m_axis_tready <= ($urandom_range(99) >= rcv_stall_pct);
	end

	// Digest word check against the oldest expectation
	always @(posedge clk) begin
		digest_out_t got;
		digest_out_t want;
		if (m_axis_tvalid && m_axis_tready) begin
			got.digest = m_axis_tdata[DIGEST_LSB +: WORD_W];
			got.idx    = m_axis_tdata[INDEX_LSB +: OIDX_W];
			got.last   = m_axis_tlast;
			if (digest_q.size() == 0) begin
				errors++;
				$display("%0t: unexpected digest word, expected none got %h/%0d/%0b",
					$time, got.digest, got.idx, got.last);
			end else begin
				want = digest_q.pop_front();
				digests_checked++;
				if (got != want) begin
					errors++;
					$display("%0t: mismatch expected %h/%0d/%0b got %h/%0d/%0b",
						$time, want.digest, want.idx, want.last,
						got.digest, got.idx, got.last);
				end
			end
		end
	end

	// Run limit
	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt == CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d digest words outstanding",
				cycle_cnt, digest_q.size());
			$display("FAIL sha256_block_compress_core");
			$finish;
		end
	end

	// Stimulus
	initial begin
		int    phase_words;
		int    phase_blocks;
		word_t vals [NUM_CV];

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int r = 0; r < NUM_DIRECTED; r++)
			send_word(DIRECTED[r].word, DIRECTED[r].start, DIRECTED[r].typed);

		// Idling phases, each with its own init words
		for (int p = 0; p < 4; p++) begin
			wait_drained();
			case (p)
				0: begin send_idle_pct = 0;  rcv_stall_pct = 0;  end
				1: begin send_idle_pct = 49; rcv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  rcv_stall_pct = 49; end
				default: begin send_idle_pct = 21; rcv_stall_pct = 21; end
			endcase
			for (int i = 0; i < NUM_CV; i++) begin
				case (p)
					0:       vals[i] = '0;
					1:       vals[i] = '1;
					2:       vals[i] = $urandom;
					default: vals[i] = IV_RESET[i];
				endcase
			end
			program_init(vals);
			phase_words  = words_sent;
			phase_blocks = blocks_done;
			while (words_sent - phase_words < WIN_DEPTH || blocks_done - phase_blocks < 1)
				send_segment();
		end

		wait_drained();
		$display("sent %0d words (%0d directed), %0d blocks compressed, %0d digest words checked",
			words_sent, NUM_DIRECTED, blocks_done, digests_checked);
		$display("%0d register writes over four init settings and four stall mixes",
			cfg_writes);
		if (errors == 0)
			$display("PASS sha256_block_compress_core");
		else
			$display("FAIL sha256_block_compress_core");
		$finish;
	end

endmodule
